// ===== rtl/depth_pixel_to_world_point_defines.svh =====
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_defines.svh
// Assertion macros for the point back-projection RTL.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_DEFINES_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_DEFINES_SVH

// Check cons in the same cycle as ante
`define DPW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define DPW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dpw_pkg
// Widths, constants and register codes of the depth pixel back-projection.
// ----------------------------------------------------------------------------
`default_nettype none

package dpw_pkg;

  // Frame geometry
  localparam int SUBSAMPLE_STEP = 4;
  localparam int MAX_ROWS       = 1024;
  localparam int MAX_COLS       = 2048;

  // Field widths
  localparam int ROW_W    = 10;
  localparam int COL_W    = 11;
  localparam int CODE_W   = 8;
  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;
  localparam int WORLD_W  = 24;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int FOCAL_W     = 24;
  localparam int CENTER_W    = 15;
  localparam int CENTER_FRAC = 4;
  localparam int COEF_W      = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INV_FOCAL_X = 3'd0,
    REG_INV_FOCAL_Y = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_MAX_DEPTH   = 3'd4,
    REG_ROW_X       = 3'd5,
    REG_ROW_Y       = 3'd6,
    REG_ROW_Z       = 3'd7
  } cfg_reg_t;

  // Register defaults (world x, y, z from camera depth, x, y at unit scale)
  localparam logic [FOCAL_W-1:0]    RST_INV_FOCAL = 24'd32768;
  localparam logic [CENTER_W-1:0]   RST_CENTER_X  = 15'd8192;
  localparam logic [CENTER_W-1:0]   RST_CENTER_Y  = 15'd4608;
  localparam logic [CODE_W-1:0]     RST_MAX_DEPTH = 8'd127;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_X     = 64'd4096;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_Y     = 64'd268435456;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_Z     = 64'd17592186044416;

  // Depth code to Q7.8: floor((code*25600 + 127) / 255) by reciprocal
  localparam int DEPTH_N_W    = 23;
  localparam int DEPTH_SCALE  = 25600;
  localparam int DEPTH_BIAS   = 127;
  localparam int DEPTH_RECIP  = 8421505;  // ceil(2^31 / 255)
  localparam int DEPTH_SHIFT  = 31;
  localparam int DEPTH_P_W    = DEPTH_N_W + 24;
  localparam int DEPTH_W      = 15;
  localparam int DEPTH_MAX_Q8 = 25600;

  // Back-projection widths
  localparam int OFS_W    = CENTER_W + 2;         // signed pixel offset, Q.4
  localparam int FOC_P_W  = OFS_W + FOCAL_W + 1;  // offset * inv_focal
  localparam int PRJ_W    = FOC_P_W + DEPTH_W + 1;
  localparam int ROUND_SH = 20;
  localparam int XY_W     = 36;                   // Q.16 lateral coordinate
  localparam int Z_W      = DEPTH_W + 9;          // Q.16 depth, signed
  localparam int Z_SH     = 8;

  // Transform widths
  localparam int PZ_W   = COEF_W + Z_W;           // coefficient * depth
  localparam int PXY_W  = COEF_W + XY_W;          // coefficient * lateral
  localparam int ACC_W  = 56;
  localparam int OFF_SH = 24;
  localparam int RES_W  = ACC_W - ROUND_SH;

  // Pipeline depth from input register to output register
  localparam int NSTAGES = 6;

  // Pixel lies inside the frame and on the subsample grid
  function automatic logic on_grid(input logic [ROW_W-1:0] row,
                                   input logic [COL_W-1:0] col);
    logic in_frame;
    in_frame = (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
    return in_frame && ((int'(row) % SUBSAMPLE_STEP) == 0)
                    && ((int'(col) % SUBSAMPLE_STEP) == 0);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dpw_if.sv =====
// ----------------------------------------------------------------------------
// dpw_if
// Valid/ready channels for pixels in and world points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpw_pixel_if
  import dpw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  pixel_row;
  logic [COL_W-1:0]  pixel_col;
  logic [CODE_W-1:0] depth_code;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] red;

  modport source (output valid, pixel_row, pixel_col, depth_code, blue, green, red,
                  input ready);
  modport sink   (input valid, pixel_row, pixel_col, depth_code, blue, green, red,
                  output ready);
endinterface

interface dpw_point_if
  import dpw_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [WORLD_W-1:0] world_x;
  logic signed [WORLD_W-1:0] world_y;
  logic signed [WORLD_W-1:0] world_z;
  logic [COLOR_W-1:0]        packed_color;

  modport source (output valid, world_x, world_y, world_z, packed_color,
                  input ready);
  modport sink   (input valid, world_x, world_y, world_z, packed_color,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/depth_pixel_to_world_point.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point
// Back-projects subsampled depth pixels through a pinhole model and an
// affine transform into saturated Q15.8 world points with packed RGB.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake       Payload
//  pixel     in    valid / ready   pixel_row, pixel_col, depth_code, blue, green, red
//  point     out   valid / ready   world_x, world_y, world_z, packed_color
//  cfg       in    cfg_write       cfg_index, cfg_data
//
//  One pixel per clock unless the output stalls. A kept pixel reaches point
//  via the stage registers; off-grid, out-of-frame or far pixels leave no result.
//  The six stages share one enable, held low only while the output register
//  is full and not taken; a stall freezes every stage in place.
//  Reset clears the stage valid bits and loads the register defaults.
//
`default_nettype none
`include "depth_pixel_to_world_point_defines.svh"

module depth_pixel_to_world_point
  import dpw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  dpw_pixel_if.sink              pixel,
  dpw_point_if.source            point
);

  localparam logic signed [PRJ_W-1:0] HALF = PRJ_W'(1) <<< (ROUND_SH - 1);

  // Configuration registers
  logic [FOCAL_W-1:0]    inv_focal_x, inv_focal_y;
  logic [CENTER_W-1:0]   center_x, center_y;
  logic [CODE_W-1:0]     max_depth_code;
  logic [CFG_DATA_W-1:0] row_x, row_y, row_z;

  // Pipeline control
  logic               adv;
  logic               accept;
  logic               keep;
  logic [NSTAGES-1:0] vld;

  // Stage payloads
  logic [DEPTH_N_W-1:0]     depth_n;
  logic [DEPTH_P_W-1:0]     depth_p;
  logic [DEPTH_W-1:0]       depth1, depth2, depth3;
  logic signed [OFS_W-1:0]  du, dv, du1, dv1;
  logic signed [FOC_P_W-1:0] ax2, ay2;
  logic signed [PRJ_W-1:0]  x_prj, y_prj;
  logic signed [XY_W-1:0]   x16, y16;
  logic signed [Z_W-1:0]    z16;
  logic [COLOR_W-1:0]       color [NSTAGES];

  // Stall only when the output register holds an untaken result
  assign adv         = !vld[NSTAGES-1] || point.ready;
  assign pixel.ready = adv;
  assign accept      = pixel.valid && adv;
  assign keep        = on_grid(pixel.pixel_row, pixel.pixel_col)
                       && (pixel.depth_code <= max_depth_code);

  // Depth code to Q7.8 and pixel offsets from the principal point
  always_comb begin
    depth_n = DEPTH_N_W'(pixel.depth_code) * DEPTH_N_W'(DEPTH_SCALE)
              + DEPTH_N_W'(DEPTH_BIAS);
    depth_p = DEPTH_P_W'(depth_n) * DEPTH_P_W'(DEPTH_RECIP);
    du = $signed(OFS_W'({pixel.pixel_col, CENTER_FRAC'(0)}))
         - $signed(OFS_W'(center_x));
    dv = $signed(OFS_W'({pixel.pixel_row, CENTER_FRAC'(0)}))
         - $signed(OFS_W'(center_y));
  end

  // Second multiply by depth, round to Q.16
  always_comb begin
    x_prj = PRJ_W'(ax2) * PRJ_W'($signed({1'b0, depth2}));
    y_prj = PRJ_W'(ay2) * PRJ_W'($signed({1'b0, depth2}));
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_focal_x    <= RST_INV_FOCAL;
      inv_focal_y    <= RST_INV_FOCAL;
      center_x       <= RST_CENTER_X;
      center_y       <= RST_CENTER_Y;
      max_depth_code <= RST_MAX_DEPTH;
      row_x          <= RST_ROW_X;
      row_y          <= RST_ROW_Y;
      row_z          <= RST_ROW_Z;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INV_FOCAL_X: inv_focal_x    <= cfg_data[FOCAL_W-1:0];
        REG_INV_FOCAL_Y: inv_focal_y    <= cfg_data[FOCAL_W-1:0];
        REG_CENTER_X:    center_x       <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:    center_y       <= cfg_data[CENTER_W-1:0];
        REG_MAX_DEPTH:   max_depth_code <= cfg_data[CODE_W-1:0];
        REG_ROW_X:       row_x          <= cfg_data;
        REG_ROW_Y:       row_y          <= cfg_data;
        REG_ROW_Z:       row_z          <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Shift valid bits; drop rejected pixels at entry
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGES-2:0], accept && keep};
    end
  end

  // Advance payload through the front stages; color runs through all stages
  always_ff @(posedge clk) begin
    if (adv) begin
      depth1 <= depth_p[DEPTH_SHIFT +: DEPTH_W];
      du1    <= du;
      dv1    <= dv;
      ax2    <= FOC_P_W'(du1) * FOC_P_W'($signed({1'b0, inv_focal_x}));
      ay2    <= FOC_P_W'(dv1) * FOC_P_W'($signed({1'b0, inv_focal_y}));
      depth2 <= depth1;
      x16    <= XY_W'((x_prj + HALF) >>> ROUND_SH);
      y16    <= XY_W'((y_prj + HALF) >>> ROUND_SH);
      depth3 <= depth2;
      color[0] <= {pixel.red, pixel.green, pixel.blue};
      for (int i = 1; i < NSTAGES; i++) begin
        color[i] <= color[i-1];
      end
    end
  end

  assign z16 = $signed({1'b0, depth3, Z_SH'(0)});

  // Transform rows: stages four to six
  dpw_axis u_axis_x (
    .clk   (clk),
    .en    (adv),
    .coefs (row_x),
    .z16   (z16),
    .x16   (x16),
    .y16   (y16),
    .world (point.world_x)
  );

  dpw_axis u_axis_y (
    .clk   (clk),
    .en    (adv),
    .coefs (row_y),
    .z16   (z16),
    .x16   (x16),
    .y16   (y16),
    .world (point.world_y)
  );

  dpw_axis u_axis_z (
    .clk   (clk),
    .en    (adv),
    .coefs (row_z),
    .z16   (z16),
    .x16   (x16),
    .y16   (y16),
    .world (point.world_z)
  );

  assign point.valid        = vld[NSTAGES-1];
  assign point.packed_color = color[NSTAGES-1];

  // Checks
  `DPW_ASSERT_NEXT(a_drop_off_grid, clk, rst,
    accept && !on_grid(pixel.pixel_row, pixel.pixel_col), !vld[0],
    "off-grid pixel entered the pipeline")
  `DPW_ASSERT_NEXT(a_drop_far, clk, rst,
    accept && (pixel.depth_code > max_depth_code), !vld[0],
    "far pixel entered the pipeline")
  `DPW_ASSERT_NEXT(a_hold_on_stall, clk, rst, !adv, $stable(vld),
    "valid bits moved during a stall")
  `DPW_ASSERT_NOW(a_depth_range, clk, rst, vld[0], depth1 <= DEPTH_W'(DEPTH_MAX_Q8),
    "converted depth above full scale")

endmodule

`default_nettype wire

// ===== rtl/dpw_axis.sv =====
// ----------------------------------------------------------------------------
// dpw_axis
// One row of the affine transform: three products, offset, round, saturate.
// Three register stages: products, partial sums, saturated result.
// ----------------------------------------------------------------------------
`default_nettype none

module dpw_axis
  import dpw_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic [CFG_DATA_W-1:0]     coefs,
  input  logic signed [Z_W-1:0]     z16,
  input  logic signed [XY_W-1:0]    x16,
  input  logic signed [XY_W-1:0]    y16,
  output logic signed [WORLD_W-1:0] world
);

  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (ROUND_SH - 1);
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(2 ** (WORLD_W - 1) - 1);
  localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [COEF_W-1:0]        c_z, c_x, c_y, c_off;
  logic signed [PZ_W-1:0]          pz;
  logic signed [PXY_W-1:0]         px, py;
  logic signed [COEF_W-1:0]        off;
  logic signed [ACC_W-1:0]         sa, sb;
  logic signed [ACC_W-1:0]         sum;
  logic signed [RES_W-1:0]         res;
  logic signed [WORLD_W-1:0]       sat;

  // Split the register row into coefficients and offset
  assign c_z   = $signed(coefs[0*COEF_W +: COEF_W]);
  assign c_x   = $signed(coefs[1*COEF_W +: COEF_W]);
  assign c_y   = $signed(coefs[2*COEF_W +: COEF_W]);
  assign c_off = $signed(coefs[3*COEF_W +: COEF_W]);

  // Round half up to Q.8 and clamp
  always_comb begin
    sum = sa + sb;
    res = sum[ROUND_SH +: RES_W];
    if (res > SAT_HI) begin
      sat = SAT_HI[WORLD_W-1:0];
    end else if (res < SAT_LO) begin
      sat = SAT_LO[WORLD_W-1:0];
    end else begin
      sat = res[WORLD_W-1:0];
    end
  end

  // Advance the three stages together
  always_ff @(posedge clk) begin
    if (en) begin
      pz    <= PZ_W'(c_z) * PZ_W'(z16);
      px    <= PXY_W'(c_x) * PXY_W'(x16);
      py    <= PXY_W'(c_y) * PXY_W'(y16);
      off   <= c_off;
      sa    <= ACC_W'(pz) + ACC_W'(px);
      sb    <= ACC_W'(py) + (ACC_W'(off) <<< OFF_SH) + HALF;
      world <= sat;
    end
  end

endmodule

`default_nettype wire
